// ===== rtl/midi_channel_event_encoder_unit_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the event encoder blocks.
// ----------------------------------------------------------------------------
`ifndef MIDI_CHANNEL_EVENT_ENCODER_UNIT_ASSERT_SVH
`define MIDI_CHANNEL_EVENT_ENCODER_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MCEE_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MCEE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/mcee_pkg.sv =====
// ----------------------------------------------------------------------------
// MIDI channel event encoder package
// Shared constants, message kind codes and the queued event descriptor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mcee_pkg;

  localparam int CMD_W        = 3;
  localparam int DELTA_W      = 28;
  localparam int CHAN_W       = 4;
  localparam int DATA_W       = 7;
  localparam int IN_FIELDS_W  = CMD_W + DELTA_W + CHAN_W + 2 * DATA_W;
  localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W  = 8;

  localparam int MAX_BYTES    = 7;
  localparam int IDX_W        = 3;
  localparam int GROUP_W      = 7;
  localparam int MAX_GROUPS   = 4;

  localparam int QUEUE_DEPTH_DEFAULT = 2;

  localparam logic [CMD_W-1:0] CMD_NOTE_OFF = 3'd0;
  localparam logic [CMD_W-1:0] CMD_NOTE_ON  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_KEY_PRES = 3'd2;
  localparam logic [CMD_W-1:0] CMD_CONTROL  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_PROGRAM  = 3'd4;
  localparam logic [CMD_W-1:0] CMD_PRESSURE = 3'd5;
  localparam logic [CMD_W-1:0] CMD_BEND     = 3'd6;
  localparam logic [CMD_W-1:0] CMD_UNUSED   = 3'd7;

  typedef struct packed {
    logic [MAX_BYTES-1:0][7:0] bytes;
    logic [IDX_W-1:0]          count;
  } event_t;

endpackage

// ===== rtl/midi_channel_event_encoder_unit.sv =====
// ----------------------------------------------------------------------------
// MIDI channel event encoder
// Turns channel-message requests into MIDI file track event byte streams.
// ----------------------------------------------------------------------------
// Each request yields one event on the byte stream: the delta time as a
// variable-length quantity (one to four bytes, most significant group first),
// the status byte, then one data byte for program change and channel pressure
// or two for the other kinds; tlast marks the final byte. Kind 7 is accepted
// and produces nothing. The output register sends one byte per cycle while
// m_axis_tready is high; an event is 3 to 7 bytes, back to back with no gap
// between events. Requests are taken every cycle while the descriptor queue
// (QUEUE_DEPTH entries plus one front-end stage) has room. From an empty block,
// an event's first byte passes front-end, queue, event and output registers.
`timescale 1ns / 1ps

module midi_channel_event_encoder_unit #(
  parameter int QUEUE_DEPTH = mcee_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // cmd[2:0], tick_delta[30:3], channel[34:31], first_data[41:35],
  // second_data[48:42], zero fill above
  input  logic [mcee_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // out_byte[7:0]
  output logic [mcee_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
  output logic                               m_axis_tlast
);
  import mcee_pkg::*;

  logic   f_valid;
  event_t f_data;
  logic   q_ready;
  logic   q_valid;
  event_t q_data;
  logic   q_pop;

  mcee_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (s_axis_tvalid),
    .in_ready    (s_axis_tready),
    .cmd         (s_axis_tdata[2:0]),
    .tick_delta  (s_axis_tdata[30:3]),
    .channel     (s_axis_tdata[34:31]),
    .first_data  (s_axis_tdata[41:35]),
    .second_data (s_axis_tdata[48:42]),
    .ev_valid    (f_valid),
    .ev_data     (f_data),
    .ev_ready    (q_ready)
  );

  mcee_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (f_valid),
    .push_ready (q_ready),
    .push_data  (f_data),
    .pop        (q_pop),
    .pop_valid  (q_valid),
    .pop_data   (q_data)
  );

  mcee_back u_back (
    .clk       (clk),
    .rst       (rst),
    .ev_valid  (q_valid),
    .ev_data   (q_data),
    .ev_pop    (q_pop),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (m_axis_tdata),
    .out_last  (m_axis_tlast)
  );

endmodule

// ===== rtl/mcee_front.sv =====
// ----------------------------------------------------------------------------
// Event encoder front end
// Accepts requests, drops unknown kinds and lays out the event byte list.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mcee_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [mcee_pkg::CMD_W-1:0]    cmd,
  input  logic [mcee_pkg::DELTA_W-1:0]  tick_delta,
  input  logic [mcee_pkg::CHAN_W-1:0]   channel,
  input  logic [mcee_pkg::DATA_W-1:0]   first_data,
  input  logic [mcee_pkg::DATA_W-1:0]   second_data,
  output logic                          ev_valid,
  output mcee_pkg::event_t              ev_data,
  input  logic                          ev_ready
);
  import mcee_pkg::*;

  logic                               valid;
  event_t                             ev;
  event_t                             ev_next;
  logic [IDX_W-1:0]                   ngroups;
  logic                               one_data;
  logic [MAX_GROUPS-1:0][GROUP_W-1:0] grp;
  logic                               accept;

  assign accept   = in_valid && in_ready;
  assign in_ready = !valid || ev_ready;
  assign ev_valid = valid;
  assign ev_data  = ev;

  always_comb begin
    grp = tick_delta;
    if (tick_delta >= DELTA_W'(28'h0200000)) begin
      ngroups = 3'd4;
    end else if (tick_delta >= DELTA_W'(28'h0004000)) begin
      ngroups = 3'd3;
    end else if (tick_delta >= DELTA_W'(28'h0000080)) begin
      ngroups = 3'd2;
    end else begin
      ngroups = 3'd1;
    end
    one_data = (cmd == CMD_PROGRAM) || (cmd == CMD_PRESSURE);
    ev_next = '0;
    for (int i = 0; i < MAX_GROUPS; i++) begin
      if (IDX_W'(i) < ngroups) begin
        ev_next.bytes[i] = {(IDX_W'(i) != ngroups - 3'd1),
                            grp[2'(ngroups - 3'd1 - IDX_W'(i))]};
      end
    end
    ev_next.bytes[ngroups]        = {1'b1, cmd, channel};
    ev_next.bytes[ngroups + 3'd1] = {1'b0, first_data};
    if (!one_data) begin
      ev_next.bytes[ngroups + 3'd2] = {1'b0, second_data};
    end
    ev_next.count = ngroups + (one_data ? 3'd2 : 3'd3);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (accept) begin
      valid <= (cmd != CMD_UNUSED);
    end else if (ev_ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      ev <= ev_next;
    end
  end

endmodule

// ===== rtl/mcee_queue.sv =====
// ----------------------------------------------------------------------------
// Event descriptor queue
// Small FIFO that decouples the front end from the byte sequencer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mcee_queue #(
  parameter int DEPTH = mcee_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  output logic             push_ready,
  input  mcee_pkg::event_t push_data,
  input  logic             pop,
  output logic             pop_valid,
  output mcee_pkg::event_t pop_data
);
  import mcee_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  event_t           mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (count != CNT_W'(DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_data   = mem[rd_ptr];
  assign do_push    = push && push_ready;
  assign do_pop     = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

`include "midi_channel_event_encoder_unit_assert.svh"

  `MCEE_ASSERT_SAME(a_count_bound, clk, rst, 1'b1, count <= CNT_W'(DEPTH), "queue overfilled")
  `MCEE_ASSERT_NEXT(a_push_grows, clk, rst, do_push && !do_pop, count == $past(count) + 1'b1, "push lost")
  `MCEE_ASSERT_NEXT(a_pop_shrinks, clk, rst, do_pop && !do_push, count == $past(count) - 1'b1, "pop lost")

endmodule

// ===== rtl/mcee_back.sv =====
// ----------------------------------------------------------------------------
// Event encoder back end
// Steps through the queued byte list and drives the registered byte stream.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mcee_back (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                ev_valid,
  input  mcee_pkg::event_t                    ev_data,
  output logic                                ev_pop,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [mcee_pkg::OUT_TDATA_W-1:0]    out_data,
  output logic                                out_last
);
  import mcee_pkg::*;

  logic             busy;
  event_t           cur;
  logic [IDX_W-1:0] idx;
  logic             advance;
  logic             at_last;

  assign advance = !out_valid || out_ready;
  assign at_last = (idx == cur.count - 3'd1);
  assign ev_pop  = advance && (!busy || at_last) && ev_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      idx       <= '0;
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= busy;
      if (ev_pop) begin
        busy <= 1'b1;
        idx  <= '0;
      end else if (busy && at_last) begin
        busy <= 1'b0;
      end else if (busy) begin
        idx <= idx + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ev_pop) begin
      cur <= ev_data;
    end
    if (advance && busy) begin
      out_data <= cur.bytes[idx];
      out_last <= at_last;
    end
  end

`include "midi_channel_event_encoder_unit_assert.svh"

  `MCEE_ASSERT_SAME(a_idx_in_event, clk, rst, busy, idx < cur.count, "byte index past event")
  `MCEE_ASSERT_NEXT(a_load_restarts, clk, rst, ev_pop, busy && idx == '0, "event load lost")
  `MCEE_ASSERT_NEXT(a_last_ends, clk, rst, advance && busy && at_last && !ev_pop, !busy && out_last, "event did not end")

endmodule

// ===== tb/midi_channel_event_encoder_unit_test.sv =====
// ----------------------------------------------------------------------------
// MIDI channel event encoder testbench
// Drives channel-message requests into the encoder and checks every byte of
// each track event against a predicted stream: variable-length delta time,
// status byte and one or two data bytes, with tlast on the final byte.
// Runs directed corner requests, then random requests under four flow-control
// phases on both stream sides.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module midi_channel_event_encoder_unit_test;
  import mcee_pkg::*;

  localparam int IDLE_LIMIT   = 4000;
  localparam int DRAIN_CYCLES = 20;
  localparam int RANDOM_ITEMS = 128;
  localparam int MAX_PRINTED  = 40;
  localparam logic [7:0] STATUS_BASE  = 8'h80;
  localparam logic [7:0] CONTINUE_BIT = 8'h80;

  typedef struct {
    logic [7:0] value;
    logic       last;
  } event_byte_t;

  class event_byte_scoreboard;
    event_byte_t pending_bytes[$];
    int unsigned mismatches;
    int unsigned bytes_checked;

    function new();
      mismatches    = 0;
      bytes_checked = 0;
    endfunction

    task report(input string msg);
      mismatches++;
      if (mismatches <= MAX_PRINTED) $display("MISMATCH at %0t: %s", $realtime, msg);
    endtask

    function int unsigned pending_count();
      return pending_bytes.size();
    endfunction

    function void push_byte(input logic [7:0] value, input logic last);
      event_byte_t b;
      b.value = value;
      b.last  = last;
      pending_bytes.push_back(b);
    endfunction

    function void note_request(input logic [CMD_W-1:0] kind, input logic [DELTA_W-1:0] delta,
                               input logic [CHAN_W-1:0] chan, input logic [DATA_W-1:0] d1,
                               input logic [DATA_W-1:0] d2);
      int groups;
      logic [7:0] vlq;
      groups = 1;
      if (kind == CMD_UNUSED) return;
      if (delta >= 28'h80) groups = 2;
      if (delta >= 28'h4000) groups = 3;
      if (delta >= 28'h200000) groups = 4;
      for (int g = groups - 1; g >= 0; g--) begin
        vlq = {1'b0, delta[7*g +: GROUP_W]};
        if (g != 0) vlq = vlq | CONTINUE_BIT;
        push_byte(vlq, 1'b0);
      end
      push_byte(STATUS_BASE | {1'b0, kind, chan}, 1'b0);
      if (kind == CMD_PROGRAM || kind == CMD_PRESSURE) begin
        push_byte({1'b0, d1}, 1'b1);
      end else begin
        push_byte({1'b0, d1}, 1'b0);
        push_byte({1'b0, d2}, 1'b1);
      end
    endfunction

    task check_byte(input logic [7:0] value, input logic last);
      event_byte_t want;
      bytes_checked++;
      if (pending_bytes.size() == 0) begin
        report($sformatf("unexpected byte %02h last %b", value, last));
      end else begin
        want = pending_bytes.pop_front();
        if (value !== want.value)
          report($sformatf("byte %02h, expected %02h", value, want.value));
        if (last !== want.last)
          report($sformatf("tlast %b on byte %02h, expected %b", last, value, want.last));
      end
    endtask
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [IN_TDATA_W-1:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic m_axis_tlast;

  event_byte_scoreboard model;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int idle_cycles = 0;
  int unsigned kind_seen[8];

  midi_channel_event_encoder_unit dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid === 1'b1 && m_axis_tready) model.check_byte(m_axis_tdata, m_axis_tlast);
    m_axis_tready <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready === 1'b1) ||
        (m_axis_tvalid === 1'b1 && m_axis_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Timed out: no request or byte moved for %0d cycles.", IDLE_LIMIT);
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic logic [IN_TDATA_W-1:0] pack_request(
      input logic [CMD_W-1:0] kind, input logic [DELTA_W-1:0] delta,
      input logic [CHAN_W-1:0] chan, input logic [DATA_W-1:0] d1, input logic [DATA_W-1:0] d2);
    logic [IN_TDATA_W-1:0] word;
    word = '0;
    word[IN_FIELDS_W-1:0] = {d2, d1, chan, delta, kind};
    return word;
  endfunction

  task automatic send_request(input logic [CMD_W-1:0] kind, input logic [DELTA_W-1:0] delta,
                              input logic [CHAN_W-1:0] chan, input logic [DATA_W-1:0] d1,
                              input logic [DATA_W-1:0] d2);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= pack_request(kind, delta, chan, d1, d2);
    do @(posedge clk); while (s_axis_tready !== 1'b1);
    model.note_request(kind, delta, chan, d1, d2);
    kind_seen[kind]++;
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (model.pending_count() != 0) @(posedge clk);
  endtask

  function automatic logic [DELTA_W-1:0] random_delta();
    case ($urandom_range(4))
      0: return DELTA_W'($urandom_range(28'h7f));
      1: return DELTA_W'($urandom_range(28'h3fff, 28'h80));
      2: return DELTA_W'($urandom_range(28'h1fffff, 28'h4000));
      3: return DELTA_W'($urandom_range(28'hfffffff, 28'h200000));
      default: return DELTA_W'($urandom());
    endcase
  endfunction

  task automatic run_random(input int count);
    logic [CMD_W-1:0] kind;
    int sent;
    sent = 0;
    while (sent < count) begin
      kind = ($urandom_range(11) == 0) ? CMD_UNUSED : CMD_W'($urandom_range(CMD_BEND));
      send_request(kind, random_delta(), CHAN_W'($urandom()), DATA_W'($urandom()),
                   DATA_W'($urandom()));
      if (kind != CMD_UNUSED) sent++;
    end
    wait_drained();
  endtask

  initial begin
    logic [DELTA_W-1:0] edges[8];
    model = new();
    edges = '{28'h0, 28'h7f, 28'h80, 28'h3fff, 28'h4000, 28'h1fffff, 28'h200000, 28'hfffffff};
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int k = 0; k < 8; k++)
      send_request(CMD_W'(k), edges[k], (k % 2) ? 4'hf : 4'h0, (k % 2) ? 7'h7f : 7'h00,
                   (k % 2) ? 7'h00 : 7'h7f);
    for (int k = 0; k < 8; k++)
      send_request(CMD_W'(CMD_PROGRAM - (k % 2)), edges[7 - k], CHAN_W'(k * 2),
                   DATA_W'(7'h7f - k), 7'h7f);
    send_request(CMD_NOTE_ON, 28'h0, 4'hf, 7'h7f, 7'h7f);
    send_request(CMD_UNUSED, 28'hfffffff, 4'hf, 7'h7f, 7'h7f);
    send_request(CMD_BEND, 28'h0, 4'h0, 7'h00, 7'h00);
    wait_drained();

    run_random(RANDOM_ITEMS / 4);
    send_idle_pct = 71;
    run_random(RANDOM_ITEMS / 4);
    send_idle_pct = 0;
    recv_stall_pct = 71;
    run_random(RANDOM_ITEMS / 4);
    send_idle_pct = 35;
    recv_stall_pct = 35;
    run_random(RANDOM_ITEMS / 4);
    send_idle_pct = 0;
    recv_stall_pct = 0;

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (model.pending_count() != 0)
      model.report($sformatf("%0d expected bytes never arrived", model.pending_count()));

    $display("Requests per kind 0..7: %0d %0d %0d %0d %0d %0d %0d %0d", kind_seen[0],
             kind_seen[1], kind_seen[2], kind_seen[3], kind_seen[4], kind_seen[5],
             kind_seen[6], kind_seen[7]);
    $display("%0d event bytes checked over four flow-control phases, %0d mismatches.",
             model.bytes_checked, model.mismatches);
    if (model.mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
